/* hw/rtl/tmsl_pkg.sv */
// ----------------------------------------------------------------------------
// tmsl_pkg
// Shared types and constants for the timestamp merge sorted list.
// ----------------------------------------------------------------------------
package tmsl_pkg;

	localparam int MAX_STREAMS_DEF    = 16;
	localparam int TIMESTAMP_BITS_DEF = 32;
	localparam int PAYLOAD_BITS_DEF   = 32;
	localparam int STREAM_BITS        = 4;

	// command codes
	localparam logic CMD_ADVANCE = 1'b1;

	// per-beat control broadcast to every cell
	typedef struct packed {
		logic pop;  // remove head, shift list toward the head
		logic ins;  // place the carried event into the list
	} ctl_t;

endpackage

/* hw/rtl/tmsl_cell.sv */
// ----------------------------------------------------------------------------
// tmsl_cell
// One slot of the sorted list: holds an entry, compares it against the
// incoming timestamp and takes its next value from itself, a neighbor or the event.
// ----------------------------------------------------------------------------
module tmsl_cell #(
	parameter int TIMESTAMP_BITS = tmsl_pkg::TIMESTAMP_BITS_DEF,
	parameter int PAYLOAD_BITS   = tmsl_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tmsl_pkg::ctl_t                   ctl,
	input  logic                             head_cell,
	input  logic [TIMESTAMP_BITS-1:0]        ev_ts,
	input  logic [PAYLOAD_BITS-1:0]          ev_pl,
	input  logic [tmsl_pkg::STREAM_BITS-1:0] ev_stream,
	input  logic                             left_valid,
	input  logic [TIMESTAMP_BITS-1:0]        left_ts,
	input  logic [PAYLOAD_BITS-1:0]          left_pl,
	input  logic [tmsl_pkg::STREAM_BITS-1:0] left_stream,
	input  logic                             left_le,
	input  logic                             right_valid,
	input  logic [TIMESTAMP_BITS-1:0]        right_ts,
	input  logic [PAYLOAD_BITS-1:0]          right_pl,
	input  logic [tmsl_pkg::STREAM_BITS-1:0] right_stream,
	input  logic                             right_le,
	output logic                             valid,
	output logic [TIMESTAMP_BITS-1:0]        ts,
	output logic [PAYLOAD_BITS-1:0]          pl,
	output logic [tmsl_pkg::STREAM_BITS-1:0] stream,
	output logic                             le
);
	import tmsl_pkg::*;

	logic                      valid_q;
	logic [TIMESTAMP_BITS-1:0] ts_q;
	logic [PAYLOAD_BITS-1:0]   pl_q;
	logic [STREAM_BITS-1:0]    stream_q;

	// contents of this slot and the slot before it once the head is removed
	logic                      sh_valid, sh_le;
	logic [TIMESTAMP_BITS-1:0] sh_ts;
	logic [PAYLOAD_BITS-1:0]   sh_pl;
	logic [STREAM_BITS-1:0]    sh_stream;
	logic                      pv_valid, pv_le;
	logic [TIMESTAMP_BITS-1:0] pv_ts;
	logic [PAYLOAD_BITS-1:0]   pv_pl;
	logic [STREAM_BITS-1:0]    pv_stream;

	logic                      nx_valid;
	logic [TIMESTAMP_BITS-1:0] nx_ts;
	logic [PAYLOAD_BITS-1:0]   nx_pl;
	logic [STREAM_BITS-1:0]    nx_stream;

	assign le = valid_q && (ts_q <= ev_ts);

	always_comb begin
		if (ctl.pop) begin
			sh_valid  = right_valid;
			sh_ts     = right_ts;
			sh_pl     = right_pl;
			sh_stream = right_stream;
			sh_le     = right_le;
			pv_valid  = valid_q;
			pv_ts     = ts_q;
			pv_pl     = pl_q;
			pv_stream = stream_q;
			pv_le     = head_cell | le;
		end else begin
			sh_valid  = valid_q;
			sh_ts     = ts_q;
			sh_pl     = pl_q;
			sh_stream = stream_q;
			sh_le     = le;
			pv_valid  = left_valid;
			pv_ts     = left_ts;
			pv_pl     = left_pl;
			pv_stream = left_stream;
			pv_le     = head_cell | left_le;
		end

		nx_valid  = sh_valid;
		nx_ts     = sh_ts;
		nx_pl     = sh_pl;
		nx_stream = sh_stream;
		// keep entries not later than the event; the boundary slot takes the event,
		// slots behind it take their predecessor
		if (ctl.ins && !sh_le) begin
			if (pv_le) begin
				nx_valid  = 1'b1;
				nx_ts     = ev_ts;
				nx_pl     = ev_pl;
				nx_stream = ev_stream;
			end else begin
				nx_valid  = pv_valid;
				nx_ts     = pv_ts;
				nx_pl     = pv_pl;
				nx_stream = pv_stream;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nx_valid;
		end
	end

	always_ff @(posedge clk) begin
		ts_q     <= nx_ts;
		pl_q     <= nx_pl;
		stream_q <= nx_stream;
	end

	assign valid  = valid_q;
	assign ts     = ts_q;
	assign pl     = pl_q;
	assign stream = stream_q;

endmodule

/* hw/rtl/timestamp_merge_sorted_list_unit.sv */
// Latency: a beat accepted at one edge shows its result with done high in the next cycle.
// Throughput: one beat per cycle; the whole row of cells updates at once, driven by
// the broadcast compare and the neighbor select in each cell.
// busy stays low; the receiver cannot stall and every result is shown for one cycle.
// Reset clears the entry count and every cell's valid bit; entry contents are not reset.
// ----------------------------------------------------------------------------
// timestamp_merge_sorted_list_unit
// Shift-register sorted list merging timestamp-ordered streams: insert an
// event, or emit the head and insert any follow-up of its stream.
// ----------------------------------------------------------------------------
module timestamp_merge_sorted_list_unit #(
	parameter int MAX_STREAMS    = tmsl_pkg::MAX_STREAMS_DEF,
	parameter int TIMESTAMP_BITS = tmsl_pkg::TIMESTAMP_BITS_DEF,
	parameter int PAYLOAD_BITS   = tmsl_pkg::PAYLOAD_BITS_DEF,
	parameter int COUNT_BITS     = $clog2(MAX_STREAMS + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             cmd,
	input  logic                             has_event,
	input  logic [tmsl_pkg::STREAM_BITS-1:0] event_stream,
	input  logic [TIMESTAMP_BITS-1:0]        event_timestamp,
	input  logic [PAYLOAD_BITS-1:0]          event_payload,
	output logic                             done,
	output logic                             emitted,
	output logic [tmsl_pkg::STREAM_BITS-1:0] out_stream,
	output logic [TIMESTAMP_BITS-1:0]        out_timestamp,
	output logic [PAYLOAD_BITS-1:0]          out_payload,
	output logic [COUNT_BITS-1:0]            pending_count,
	output logic                             overflow
);
	import tmsl_pkg::*;

	localparam logic [COUNT_BITS-1:0] FULL = COUNT_BITS'(MAX_STREAMS);

	logic [COUNT_BITS-1:0] count_q, count_nx;
	logic                  accept, pop, full, ins, drop;
	ctl_t                  ctl;
	logic [STREAM_BITS-1:0] ins_stream;

	logic                      c_valid  [MAX_STREAMS];
	logic [TIMESTAMP_BITS-1:0] c_ts     [MAX_STREAMS];
	logic [PAYLOAD_BITS-1:0]   c_pl     [MAX_STREAMS];
	logic [STREAM_BITS-1:0]    c_stream [MAX_STREAMS];
	logic                      c_le     [MAX_STREAMS];

	logic [MAX_STREAMS-1:0]    valid_vec;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == FULL);
	assign pop    = accept && (cmd == CMD_ADVANCE) && (count_q != '0);
	assign ins    = accept && has_event && (pop || !full);
	assign drop   = accept && has_event && !pop && full;

	// a follow-up event belongs to the stream of the head it replaces
	assign ins_stream = pop ? c_stream[0] : event_stream;

	assign ctl.pop = pop;
	assign ctl.ins = ins;

	assign count_nx = count_q - COUNT_BITS'(pop) + COUNT_BITS'(ins);

	genvar i;
	generate
		for (i = 0; i < MAX_STREAMS; i++) begin : g_cell
			logic                      l_valid, l_le, r_valid, r_le;
			logic [TIMESTAMP_BITS-1:0] l_ts, r_ts;
			logic [PAYLOAD_BITS-1:0]   l_pl, r_pl;
			logic [STREAM_BITS-1:0]    l_stream, r_stream;

			if (i == 0) begin : g_first
				assign l_valid  = 1'b0;
				assign l_ts     = '0;
				assign l_pl     = '0;
				assign l_stream = '0;
				assign l_le     = 1'b0;
			end else begin : g_mid_l
				assign l_valid  = c_valid[i-1];
				assign l_ts     = c_ts[i-1];
				assign l_pl     = c_pl[i-1];
				assign l_stream = c_stream[i-1];
				assign l_le     = c_le[i-1];
			end

			if (i == MAX_STREAMS - 1) begin : g_last
				assign r_valid  = 1'b0;
				assign r_ts     = '0;
				assign r_pl     = '0;
				assign r_stream = '0;
				assign r_le     = 1'b0;
			end else begin : g_mid_r
				assign r_valid  = c_valid[i+1];
				assign r_ts     = c_ts[i+1];
				assign r_pl     = c_pl[i+1];
				assign r_stream = c_stream[i+1];
				assign r_le     = c_le[i+1];
			end

			tmsl_cell #(
				.TIMESTAMP_BITS(TIMESTAMP_BITS),
				.PAYLOAD_BITS  (PAYLOAD_BITS)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.head_cell   ((i == 0) ? 1'b1 : 1'b0),
				.ev_ts       (event_timestamp),
				.ev_pl       (event_payload),
				.ev_stream   (ins_stream),
				.left_valid  (l_valid),
				.left_ts     (l_ts),
				.left_pl     (l_pl),
				.left_stream (l_stream),
				.left_le     (l_le),
				.right_valid (r_valid),
				.right_ts    (r_ts),
				.right_pl    (r_pl),
				.right_stream(r_stream),
				.right_le    (r_le),
				.valid       (c_valid[i]),
				.ts          (c_ts[i]),
				.pl          (c_pl[i]),
				.stream      (c_stream[i]),
				.le          (c_le[i])
			);

			assign valid_vec[i] = c_valid[i];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			done          <= 1'b0;
			emitted       <= 1'b0;
			out_stream    <= '0;
			out_timestamp <= '0;
			out_payload   <= '0;
			pending_count <= '0;
			overflow      <= 1'b0;
		end else begin
			done <= accept;
			if (accept) begin
				count_q       <= count_nx;
				emitted       <= pop;
				out_stream    <= pop ? c_stream[0] : '0;
				out_timestamp <= pop ? c_ts[0] : '0;
				out_payload   <= pop ? c_pl[0] : '0;
				pending_count <= count_nx;
				overflow      <= drop;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("cell valid bits disagree with entry count");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_vec[1] |-> (c_ts[0] <= c_ts[1]))
		else $error("head entry later than its successor");

	a_result_follows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done && (pending_count == count_q))
		else $error("result missing or count mismatch after accepted beat");

	a_overflow_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (!emitted && pending_count == FULL))
		else $error("overflow flagged on an emitting or non-full step");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timestamp merge sorted list: a directed table
// covers empty, tie, follow-up and full-list cases, then random merge
// sessions, fill-to-overflow runs and noise are checked against a predictor.
// ----------------------------------------------------------------------------
module tb_top;
	import tmsl_pkg::*;

	localparam logic CMD_INSERT  = 1'b0;
	localparam int   MAX_HELD    = MAX_STREAMS_DEF;
	localparam int   RANDOM_BEATS = 1600;
	localparam int   STALL_LIMIT = 2000;

	typedef struct packed {
		logic                   emitted;
		logic [STREAM_BITS-1:0] stream;
		logic [31:0]            ts;
		logic [31:0]            pl;
		logic [4:0]             count;
		logic                   overflow;
	} merge_result_t;

	typedef struct packed {
		logic                   cmd;
		logic                   has_ev;
		logic [STREAM_BITS-1:0] stream;
		logic [31:0]            ts;
		logic [31:0]            pl;
		logic                   literal;
		merge_result_t          want;
	} stim_row_t;

	localparam merge_result_t NONE = '0;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic                   cmd;
	logic                   has_event;
	logic [STREAM_BITS-1:0] event_stream;
	logic [31:0]            event_timestamp;
	logic [31:0]            event_payload;
	logic                   done;
	logic                   emitted;
	logic [STREAM_BITS-1:0] out_stream;
	logic [31:0]            out_timestamp;
	logic [31:0]            out_payload;
	logic [4:0]             pending_count;
	logic                   overflow;

	// row-supplied expectation, driven along with the beat
	logic          row_literal;
	merge_result_t row_want;

	// predictor copy of the sorted list
	logic [31:0]            held_ts [MAX_HELD];
	logic [31:0]            held_pl [MAX_HELD];
	logic [STREAM_BITS-1:0] held_stream [MAX_HELD];
	int                     held_count;

	merge_result_t expected_merge_q [$];
	int            err_count;
	int            result_index;
	int            stall_cycles;
	bit            no_idle;
	stim_row_t     directed_rows [24];

	timestamp_merge_sorted_list_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.has_event       (has_event),
		.event_stream    (event_stream),
		.event_timestamp (event_timestamp),
		.event_payload   (event_payload),
		.done            (done),
		.emitted         (emitted),
		.out_stream      (out_stream),
		.out_timestamp   (out_timestamp),
		.out_payload     (out_payload),
		.pending_count   (pending_count),
		.overflow        (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Pop the head on advance, then place the event after all equal timestamps.
	function automatic merge_result_t merge_step(input logic c, input logic h,
			input logic [STREAM_BITS-1:0] s, input logic [31:0] t, input logic [31:0] p);
		merge_result_t          r;
		int                     pos;
		logic [STREAM_BITS-1:0] ins_stream;
		r = '0;
		ins_stream = s;
		if (c == CMD_ADVANCE && held_count > 0) begin
			r.emitted = 1'b1;
			r.stream  = held_stream[0];
			r.ts      = held_ts[0];
			r.pl      = held_pl[0];
			for (int k = 1; k < held_count; k++) begin
				held_ts[k-1]     = held_ts[k];
				held_pl[k-1]     = held_pl[k];
				held_stream[k-1] = held_stream[k];
			end
			held_count--;
			ins_stream = r.stream;
		end
		if (h) begin
			if (held_count >= MAX_HELD) begin
				r.overflow = 1'b1;
			end else begin
				pos = 0;
				while (pos < held_count && held_ts[pos] <= t)
					pos++;
				for (int k = held_count; k > pos; k--) begin
					held_ts[k]     = held_ts[k-1];
					held_pl[k]     = held_pl[k-1];
					held_stream[k] = held_stream[k-1];
				end
				held_ts[pos]     = t;
				held_pl[pos]     = p;
				held_stream[pos] = ins_stream;
				held_count++;
			end
		end
		r.count = 5'(held_count);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (err_count < 100)
			$display("mismatch result %0d %s: got %0h want %0h", result_index, what, got,
				want);
		err_count++;
	endtask

	// Check results against the oldest expectation, then record the new beat.
	always @(posedge clk) begin
		merge_result_t w;
		if (start && !busy && arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (arst_n) begin
			if (done) begin
				if (expected_merge_q.size() == 0) begin
					report_mismatch("unexpected result", {31'd0, emitted}, 32'd0);
				end else begin
					w = expected_merge_q.pop_front();
					if (emitted !== w.emitted)
						report_mismatch("emitted", {31'd0, emitted}, {31'd0, w.emitted});
					if (out_stream !== w.stream)
						report_mismatch("out_stream", {28'd0, out_stream}, {28'd0, w.stream});
					if (out_timestamp !== w.ts)
						report_mismatch("out_timestamp", out_timestamp, w.ts);
					if (out_payload !== w.pl)
						report_mismatch("out_payload", out_payload, w.pl);
					if (pending_count !== w.count)
						report_mismatch("pending_count", {27'd0, pending_count}, {27'd0, w.count});
					if (overflow !== w.overflow)
						report_mismatch("overflow", {31'd0, overflow}, {31'd0, w.overflow});
				end
				result_index++;
			end
			if (start && !busy) begin
				w = merge_step(cmd, has_event, event_stream, event_timestamp, event_payload);
				if (row_literal)
					w = row_want;
				expected_merge_q = {expected_merge_q, w};
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [31:0] rand_timestamp();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_beat(input logic c, input logic h, input logic [STREAM_BITS-1:0] s,
			input logic [31:0] t, input logic [31:0] p, input logic lit,
			input merge_result_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start           <= 1'b1;
		cmd             <= c;
		has_event       <= h;
		event_stream    <= s;
		event_timestamp <= t;
		event_payload   <= p;
		row_literal     <= lit;
		row_want        <= want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int               beats;
		int               n;
		int               off;
		int               guard;
		bit               tight;
		logic [31:0]      base;
		logic [31:0]      nts;
		logic [32:0]      sum;
		stim_row_t        row;

		arst_n          = 1'b0;
		start           = 1'b0;
		cmd             = CMD_INSERT;
		has_event       = 1'b0;
		event_stream    = '0;
		event_timestamp = '0;
		event_payload   = '0;
		row_literal     = 1'b0;
		row_want        = NONE;
		held_count      = 0;
		err_count       = 0;
		result_index    = 0;
		stall_cycles    = 0;
		no_idle         = 1'b0;

		directed_rows = '{
			// advance and insert on an empty list
			'{CMD_ADVANCE, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1, NONE},
			'{CMD_INSERT, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1, NONE},
			'{CMD_ADVANCE, 1'b1, 4'd3, 32'd100, 32'h0000_00A1, 1'b1,
				'{1'b0, 4'd0, 32'd0, 32'd0, 5'd1, 1'b0}},
			'{CMD_INSERT, 1'b1, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NONE},
			'{CMD_INSERT, 1'b1, 4'd0, 32'd0, 32'd0, 1'b0, NONE},
			// tie with the stream 3 entry lands behind it
			'{CMD_INSERT, 1'b1, 4'd7, 32'd100, 32'h0000_00B7, 1'b0, NONE},
			// follow-up takes the head's stream, event_stream ignored
			'{CMD_ADVANCE, 1'b1, 4'd9, 32'd100, 32'h5A5A_5A5A, 1'b1,
				'{1'b1, 4'd0, 32'd0, 32'd0, 5'd4, 1'b0}},
			'{CMD_ADVANCE, 1'b0, 4'd0, 32'd0, 32'd0, 1'b0, NONE},
			// fill to capacity
			'{CMD_INSERT, 1'b1, 4'd1, 32'h8000_0000, 32'h8000_0000, 1'b0, NONE},
			'{CMD_INSERT, 1'b1, 4'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, NONE},
			'{CMD_INSERT, 1'b1, 4'd4, 32'h0000_0001, 32'hA5A5_A5A5, 1'b0, NONE},
			'{CMD_INSERT, 1'b1, 4'd5, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, NONE},
			'{CMD_INSERT, 1'b1, 4'd6, 32'd100, 32'h1111_1111, 1'b0, NONE},
			'{CMD_INSERT, 1'b1, 4'd8, 32'h5555_5555, 32'h5555_5555, 1'b0, NONE},
			'{CMD_INSERT, 1'b1, 4'd10, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, NONE},
			'{CMD_INSERT, 1'b1, 4'd11, 32'd0, 32'h0F0F_0F0F, 1'b0, NONE},
			'{CMD_INSERT, 1'b1, 4'd12, 32'h1234_5678, 32'hF0F0_F0F0, 1'b0, NONE},
			'{CMD_INSERT, 1'b1, 4'd13, 32'hFFFF_FFFE, 32'h3C3C_3C3C, 1'b0, NONE},
			'{CMD_INSERT, 1'b1, 4'd14, 32'd2, 32'hC3C3_C3C3, 1'b0, NONE},
			'{CMD_INSERT, 1'b1, 4'd9, 32'h3C3C_3C3C, 32'h7FFF_FFFF, 1'b0, NONE},
			'{CMD_INSERT, 1'b1, 4'd3, 32'h0F0F_0F0F, 32'h8000_0000, 1'b0, NONE},
			// full list drops the insert
			'{CMD_INSERT, 1'b1, 4'd15, 32'd50, 32'h2222_2222, 1'b1,
				'{1'b0, 4'd0, 32'd0, 32'd0, 5'd16, 1'b1}},
			// advance on a full list removes first, so no overflow
			'{CMD_ADVANCE, 1'b1, 4'd6, 32'd0, 32'h3333_3333, 1'b0, NONE},
			'{CMD_ADVANCE, 1'b1, 4'd0, 32'hFFFF_FFFF, 32'h4444_4444, 1'b0, NONE}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_beat(row.cmd, row.has_ev, row.stream, row.ts, row.pl, row.literal, row.want);
		end

		beats = 0;
		while (beats < RANDOM_BEATS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				7, 8: begin
					// noise: anything the fields allow
					n = $urandom_range(1, 20);
					repeat (n) begin
						send_beat(1'($urandom), 1'($urandom), 4'($urandom), rand_timestamp(),
							$urandom, 1'b0, NONE);
						beats++;
					end
				end
				9: begin
					// fill past capacity, then drain a little
					while (held_count < MAX_HELD) begin
						send_beat(CMD_INSERT, 1'b1, 4'($urandom), rand_timestamp(), $urandom,
							1'b0, NONE);
						beats++;
					end
					repeat ($urandom_range(1, 3)) begin
						send_beat(CMD_INSERT, 1'b1, 4'($urandom), rand_timestamp(), $urandom,
							1'b0, NONE);
						beats++;
					end
					repeat ($urandom_range(1, 6)) begin
						send_beat(CMD_ADVANCE, 1'($urandom), 4'($urandom), rand_timestamp(),
							$urandom, 1'b0, NONE);
						beats++;
					end
				end
				default: begin
					// merge session: one head per stream, then advance with follow-ups
					n     = $urandom_range(1, 16);
					off   = $urandom_range(0, 15);
					tight = 1'($urandom);
					base  = tight ? 32'($urandom_range(0, 20)) : 32'd0;
					for (int i = 0; i < n; i++) begin
						nts = tight ? base + 32'($urandom_range(0, 8)) : $urandom;
						send_beat(CMD_INSERT, 1'b1, 4'(i + off), nts, $urandom, 1'b0, NONE);
						beats++;
					end
					guard = 0;
					while (held_count > 0 && guard < 200) begin
						if ($urandom_range(0, 19) == 0) begin
							send_beat(CMD_INSERT, 1'b1, 4'($urandom), rand_timestamp(), $urandom,
								1'b0, NONE);
						end else begin
							if ($urandom_range(0, 9) == 0) begin
								// out-of-order follow-up
								nts = held_ts[0] >> $urandom_range(0, 4);
							end else begin
								sum = {1'b0, held_ts[0]} +
									(tight ? 33'($urandom_range(0, 4)) : 33'($urandom));
								nts = sum[32] ? held_ts[0] : sum[31:0];
							end
							send_beat(CMD_ADVANCE, ($urandom_range(0, 9) < 7), 4'($urandom), nts,
								$urandom, 1'b0, NONE);
						end
						beats++;
						guard++;
					end
				end
			endcase
		end

		start <= 1'b0;
		while (expected_merge_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
